// ===== hdl/quantized_conv2d_requant_assert.svh =====
// Assertion macros shared by the convolution block modules.
`ifndef QUANTIZED_CONV2D_REQUANT_ASSERT_SVH
`define QUANTIZED_CONV2D_REQUANT_ASSERT_SVH

// Implication checked at every rising clock edge outside reset.
`define QCR_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define QCR_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hdl/qconv_pkg.sv =====
// Package with types, constants and register indexes for the convolution block.
package qconv_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxKernel = 8;
  localparam int unsigned KStore    = MaxKernel * MaxKernel;
  localparam int unsigned LStore    = MaxKernel * MaxWidth;
  localparam int unsigned KAw       = $clog2(KStore);
  localparam int unsigned LAw       = $clog2(LStore);
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned KrW       = $clog2(MaxKernel);
  localparam int unsigned KcntW     = $clog2(KStore + 1);
  localparam int unsigned KdimW     = $clog2(MaxKernel + 1);
  localparam int unsigned WdimW     = $clog2(MaxWidth + 1);
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QAw       = $clog2(QDepth);

  typedef enum logic [2:0] {
    RegImageWidth  = 3'd0,
    RegKernelWidth = 3'd1,
    RegInputZp     = 3'd2,
    RegWeightZp    = 3'd3,
    RegOutputZp    = 3'd4,
    RegAccBias     = 3'd5,
    RegScale       = 3'd6,
    RegShift       = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StMac,
    StBias,
    StScale,
    StShift,
    StOut
  } back_state_e;

  // One window job handed from the front end to the back end.
  typedef struct packed {
    logic [15:0]     r0;
    logic [ColW-1:0] c0;
    logic [KdimW-1:0] rows;
    logic [KdimW-1:0] kw;
    logic            last;
  } job_t;

endpackage

// ===== hdl/qconv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module qconv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/qconv_front.sv =====
// Front end: stores weights and pixels, tracks position, issues window jobs.
module qconv_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic signed [7:0]         sample_i,
  input  logic                      is_last_i,
  input  logic [8:0]                image_width_i,
  input  logic [3:0]                kernel_width_i,
  input  logic signed [8:0]         input_zp_i,
  input  logic signed [8:0]         weight_zp_i,
  input  logic                      jobs_idle_i,
  output logic                      kwe_o,
  output logic [qconv_pkg::KAw-1:0] kwaddr_o,
  output logic [9:0]                kwdata_o,
  output logic                      lwe_o,
  output logic [qconv_pkg::LAw-1:0] lwaddr_o,
  output logic [9:0]                lwdata_o,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output qconv_pkg::job_t           job_o
);
  logic [qconv_pkg::KcntW-1:0] kcount_q, kcount_d;
  logic [qconv_pkg::KdimW-1:0] krows_q, krows_d;
  logic [15:0]                 row_q, row_d;
  logic [qconv_pkg::ColW-1:0]  col_q, col_d;
  logic                        row_open_q, row_open_d;
  logic [qconv_pkg::KdimW-1:0] kw;
  logic [qconv_pkg::WdimW-1:0] w;
  logic [qconv_pkg::ColW-1:0]  col;
  logic                        acc_item, fire, row_move, pix_ok;
  logic [qconv_pkg::KcntW-1:0] kcnt_new, rdiv;
  logic [16:0]                 row_p1;
  logic [qconv_pkg::ColW:0]    col_p1;

  always_comb begin
    kw = (kernel_width_i == '0) ? qconv_pkg::KdimW'(1)
       : (kernel_width_i > 4'(qconv_pkg::MaxKernel)) ? qconv_pkg::KdimW'(qconv_pkg::MaxKernel)
       : qconv_pkg::KdimW'(kernel_width_i);
    w = (image_width_i == '0) ? qconv_pkg::WdimW'(1)
      : (image_width_i > 9'(qconv_pkg::MaxWidth)) ? qconv_pkg::WdimW'(qconv_pkg::MaxWidth)
      : qconv_pkg::WdimW'(image_width_i);
  end

  assign col    = ({1'b0, col_q} >= w) ? qconv_pkg::ColW'(w - 1'b1) : col_q;
  assign row_p1 = {1'b0, row_q} + 17'd1;
  assign col_p1 = {1'b0, col} + 1'b1;
  assign fire   = req_type_i && (krows_q != '0) && (kw <= w)
               && (row_p1 >= 17'(krows_q)) && (col_p1 >= (qconv_pkg::ColW+1)'(kw));
  assign row_move = is_last_i || (col_p1 >= (qconv_pkg::ColW+1)'(w));
  // Once the position has left the row of the windows still waiting, a pixel could
  // overwrite their data, so it waits until the back end has read them all.
  // Weights always wait for that. A pixel that makes a window needs a free queue slot.
  assign pix_ok     = jobs_idle_i || row_open_q;
  assign in_ready_o = req_type_i ? (pix_ok && !(fire && !job_ready_i)) : jobs_idle_i;
  assign acc_item   = in_valid_i && in_ready_o;

  assign kwe_o    = acc_item && !req_type_i && (kcount_q < qconv_pkg::KcntW'(qconv_pkg::KStore));
  assign kwaddr_o = kcount_q[qconv_pkg::KAw-1:0];
  assign kwdata_o = 10'(10'(signed'(sample_i)) + 10'(weight_zp_i));
  assign lwe_o    = acc_item && req_type_i;
  assign lwaddr_o = {row_q[qconv_pkg::KrW-1:0], col};
  assign lwdata_o = 10'(10'(signed'(sample_i)) + 10'(input_zp_i));

  assign job_valid_o = in_valid_i && req_type_i && fire && pix_ok;
  assign job_o.r0    = 16'(row_p1 - 17'(krows_q));
  assign job_o.c0    = qconv_pkg::ColW'(col_p1 - (qconv_pkg::ColW+1)'(kw));
  assign job_o.rows  = krows_q;
  assign job_o.kw    = kw;
  assign job_o.last  = is_last_i;

  // Rows from the count: at most 64 / kw, done by repeated compare on 8 steps.
  always_comb begin
    kcnt_new = kcount_q + ((kcount_q < qconv_pkg::KcntW'(qconv_pkg::KStore)) ? 1'b1 : 1'b0);
    rdiv = '0;
    for (int i = 1; i <= qconv_pkg::MaxKernel; i++) begin
      if (kcnt_new >= qconv_pkg::KcntW'(i * kw)) rdiv = qconv_pkg::KcntW'(i);
    end
  end

  always_comb begin
    kcount_d   = kcount_q;
    krows_d    = krows_q;
    row_d      = row_q;
    col_d      = col_q;
    row_open_d = jobs_idle_i ? 1'b1 : row_open_q;
    if (acc_item) begin
      if (!req_type_i) begin
        if (is_last_i) begin
          kcount_d = '0;
          krows_d  = qconv_pkg::KdimW'(rdiv);
          row_d    = '0;
          col_d    = '0;
        end else begin
          kcount_d = kcnt_new;
          krows_d  = '0;
        end
      end else begin
        if (row_move) row_open_d = 1'b0;
        if (is_last_i) begin
          row_d = '0;
          col_d = '0;
        end else if (col_p1 >= (qconv_pkg::ColW+1)'(w)) begin
          col_d = '0;
          if (row_q != 16'hFFFF) row_d = row_q + 16'd1;
        end else begin
          col_d = qconv_pkg::ColW'(col_p1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kcount_q   <= '0;
      krows_q    <= '0;
      row_q      <= '0;
      col_q      <= '0;
      row_open_q <= 1'b1;
    end else begin
      kcount_q   <= kcount_d;
      krows_q    <= krows_d;
      row_q      <= row_d;
      col_q      <= col_d;
      row_open_q <= row_open_d;
    end
  end

  `include "quantized_conv2d_requant_assert.svh"
  `QCR_ASSERT_IMP(a_krows_cap, clk_i, rst_ni, 1'b1, krows_q <= qconv_pkg::KdimW'(qconv_pkg::MaxKernel), "kernel rows above limit")
  `QCR_ASSERT_IMP(a_kcount_cap, clk_i, rst_ni, 1'b1, kcount_q <= qconv_pkg::KcntW'(qconv_pkg::KStore), "kernel count above store")
  `QCR_ASSERT_IMP(a_job_pixel, clk_i, rst_ni, job_valid_o, req_type_i && krows_q != '0, "job without kernel")
endmodule

// ===== hdl/qconv_queue.sv =====
// Short queue of window jobs between front and back end.
module qconv_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  qconv_pkg::job_t data_i,
  output logic            empty_o,
  input  logic            pop_i,
  output qconv_pkg::job_t data_o
);
  qconv_pkg::job_t           slot_q [qconv_pkg::QDepth];
  logic [qconv_pkg::QAw-1:0] wp_q, rp_q;
  logic [qconv_pkg::QAw:0]   cnt_q;

  assign full_o  = cnt_q == (qconv_pkg::QAw+1)'(qconv_pkg::QDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = slot_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) slot_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= wp_q + 1'b1;
      if (pop_i && !empty_o) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (qconv_pkg::QAw+1)'(push_i && !full_o)
                     - (qconv_pkg::QAw+1)'(pop_i && !empty_o);
    end
  end
endmodule

// ===== hdl/qconv_back.sv =====
// Back end: serial multiply-accumulate over the window, then requantization.
module qconv_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      job_valid_i,
  output logic                      job_pop_o,
  input  qconv_pkg::job_t           job_i,
  output logic                      busy_o,
  output logic [qconv_pkg::KAw-1:0] kraddr_o,
  input  logic [9:0]                krdata_i,
  output logic [qconv_pkg::LAw-1:0] lraddr_o,
  input  logic [9:0]                lrdata_i,
  input  logic signed [8:0]         output_zp_i,
  input  logic signed [31:0]        acc_bias_i,
  input  logic signed [15:0]        scale_i,
  input  logic [5:0]                shift_i,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata,
  output logic                      m_axis_tlast
);
  qconv_pkg::back_state_e state_q, state_d;
  qconv_pkg::job_t        job_q;
  logic [qconv_pkg::KdimW-1:0] i_q, i_d, j_q, j_d;
  logic [qconv_pkg::KAw:0]     k_q, k_d;
  logic                        rd_q, rd_d;
  logic signed [31:0] acc_q, acc_d;
  logic signed [48:0] prod_q, prod_d;
  logic signed [48:0] sh_q, sh_d;
  logic signed [19:0] tap;
  logic signed [32:0] biased;
  logic signed [49:0] relu;
  logic signed [7:0]  val;
  logic [2:0]         rsel;
  logic [qconv_pkg::ColW:0] csel;
  logic               out_busy;

  assign out_busy = m_axis_tvalid && !m_axis_tready;
  assign busy_o   = (state_q == qconv_pkg::StRead) || (state_q == qconv_pkg::StMac);
  assign tap      = signed'(lrdata_i) * signed'(krdata_i);
  assign biased   = 33'(acc_q) + 33'(acc_bias_i);
  assign rsel     = 3'(job_q.r0[qconv_pkg::KrW-1:0] + qconv_pkg::KrW'(i_q));
  assign csel     = (qconv_pkg::ColW+1)'(job_q.c0) + (qconv_pkg::ColW+1)'(j_q);
  assign lraddr_o = {rsel, csel[qconv_pkg::ColW-1:0]};
  assign kraddr_o = k_q[qconv_pkg::KAw-1:0];
  assign relu     = (sh_q < 0) ? 50'sd0 : 50'(sh_q);

  always_comb begin
    logic signed [49:0] z;
    z   = relu + 50'(output_zp_i);
    val = (z > 50'sd127) ? 8'sd127 : (z < -50'sd128) ? -8'sd128 : 8'(z);
  end

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    rd_d       = 1'b0;
    acc_d      = acc_q;
    prod_d     = prod_q;
    sh_d       = sh_q;
    job_pop_o  = 1'b0;
    case (state_q)
      qconv_pkg::StIdle: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          i_d = '0; j_d = '0; k_d = '0; acc_d = '0;
          state_d = qconv_pkg::StRead;
        end
      end
      qconv_pkg::StRead, qconv_pkg::StMac: begin
        // Addresses issue one tap per cycle; the registered read data arrives in the next cycle.
        if (rd_q) acc_d = acc_q + 32'(tap);
        if (state_q == qconv_pkg::StRead) begin
          rd_d = 1'b1;
          k_d  = k_q + 1'b1;
          if (j_q + 1'b1 == job_q.kw) begin
            j_d = '0;
            i_d = i_q + 1'b1;
            if (i_q + 1'b1 == job_q.rows) state_d = qconv_pkg::StMac;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else if (!rd_q) begin
          state_d = qconv_pkg::StBias;
        end
      end
      qconv_pkg::StBias: begin
        prod_d  = 49'(biased);
        state_d = qconv_pkg::StScale;
      end
      qconv_pkg::StScale: begin
        prod_d  = 49'(signed'(prod_q[32:0]) * 49'(scale_i));
        state_d = qconv_pkg::StShift;
      end
      qconv_pkg::StShift: begin
        sh_d    = prod_q >>> shift_i;
        state_d = qconv_pkg::StOut;
      end
      qconv_pkg::StOut: begin
        if (!out_busy) state_d = qconv_pkg::StIdle;
      end
      default: state_d = qconv_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= qconv_pkg::StIdle;
      rd_q          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_q    <= rd_d;
      if (state_q == qconv_pkg::StOut && !out_busy) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) job_q <= job_i;
    i_q    <= i_d;
    j_q    <= j_d;
    k_q    <= k_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    sh_q   <= sh_d;
    if (state_q == qconv_pkg::StOut && !out_busy) begin
      m_axis_tdata <= {job_q.c0, job_q.r0[7:0], val};
      m_axis_tlast <= job_q.last;
    end
  end

  `include "quantized_conv2d_requant_assert.svh"
  `QCR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_busy, m_axis_tvalid, "result dropped while stalled")
  `QCR_ASSERT_IMP(a_pop_idle, clk_i, rst_ni, job_pop_o, state_q == qconv_pkg::StIdle && !rd_q, "job taken while busy")
endmodule

// ===== hdl/quantized_conv2d_requant.sv =====
// Top level of the quantized 2D convolution with requantization.
//  channel   dir  handshake                  content
//  s_axis    in   s_axis_tvalid/tready       tdata sample, tuser req_type, tlast is_last
//  m_axis    out  m_axis_tvalid/tready       tdata value,row,col, tlast last
//  cfg       in   cfg_valid_i/cfg_ready_o    cfg_index_i, cfg_data_i
// Pixels are taken one word a cycle; one that completes a window enqueues a job and waits
// when the four-entry job queue is full. Weights, and pixels past the row of the waiting
// windows, wait until the back end has read every queued window.
// Each job's time is set by the one serial multiply-accumulate over its rows*kw taps.
// Reset is asynchronous and clears control state; memories are not cleared.
// The output register lets the back end work through the next job while a word waits.
module quantized_conv2d_requant (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // sample
  input  logic        s_axis_tuser,   // req_type
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_value, out_row, out_col
  output logic        m_axis_tlast,   // out_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  logic [8:0] iw_q; logic [3:0] kw_q; logic [5:0] sh_q;
  logic signed [8:0] izp_q, wzp_q, ozp_q;
  logic signed [31:0] bias_q; logic signed [15:0] sc_q;
  logic kwe, lwe, jv, jfull, jempty, jpop, in_rdy, bbusy;
  logic [qconv_pkg::KAw-1:0] kwa, kra;
  logic [qconv_pkg::LAw-1:0] lwa, lra;
  logic [9:0] kwd, lwd, krd, lrd;
  qconv_pkg::job_t jin, jout;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_q <= 9'd1; kw_q <= 4'd1; izp_q <= '0; wzp_q <= '0; ozp_q <= '0;
      bias_q <= '0; sc_q <= 16'sd1; sh_q <= '0;
    end else if (cfg_valid_i) begin
      case (qconv_pkg::reg_idx_e'(cfg_index_i))
        qconv_pkg::RegImageWidth:  iw_q   <= cfg_data_i[8:0];
        qconv_pkg::RegKernelWidth: kw_q   <= cfg_data_i[3:0];
        qconv_pkg::RegInputZp:     izp_q  <= cfg_data_i[8:0];
        qconv_pkg::RegWeightZp:    wzp_q  <= cfg_data_i[8:0];
        qconv_pkg::RegOutputZp:    ozp_q  <= cfg_data_i[8:0];
        qconv_pkg::RegAccBias:     bias_q <= cfg_data_i;
        qconv_pkg::RegScale:       sc_q   <= cfg_data_i[15:0];
        qconv_pkg::RegShift:       sh_q   <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = in_rdy;

  qconv_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(in_rdy),
    .req_type_i(s_axis_tuser), .sample_i(s_axis_tdata), .is_last_i(s_axis_tlast),
    .image_width_i(iw_q), .kernel_width_i(kw_q), .input_zp_i(izp_q),
    .weight_zp_i(wzp_q), .jobs_idle_i(jempty && !bbusy),
    .kwe_o(kwe), .kwaddr_o(kwa), .kwdata_o(kwd),
    .lwe_o(lwe), .lwaddr_o(lwa), .lwdata_o(lwd), .job_valid_o(jv),
    .job_ready_i(!jfull), .job_o(jin)
  );

  qconv_queue u_queue (
    .clk_i, .rst_ni, .push_i(jv), .full_o(jfull), .data_i(jin),
    .empty_o(jempty), .pop_i(jpop), .data_o(jout)
  );

  qconv_ram #(.Width(10), .Depth(qconv_pkg::KStore)) u_kram (
    .clk_i, .we_i(kwe), .waddr_i(kwa), .wdata_i(kwd), .raddr_i(kra), .rdata_o(krd)
  );

  qconv_ram #(.Width(10), .Depth(qconv_pkg::LStore)) u_lram (
    .clk_i, .we_i(lwe), .waddr_i(lwa), .wdata_i(lwd), .raddr_i(lra), .rdata_o(lrd)
  );

  qconv_back u_back (
    .clk_i, .rst_ni, .job_valid_i(!jempty), .job_pop_o(jpop), .job_i(jout),
    .busy_o(bbusy),
    .kraddr_o(kra), .krdata_i(krd), .lraddr_o(lra), .lrdata_i(lrd),
    .output_zp_i(ozp_q), .acc_bias_i(bias_q), .scale_i(sc_q), .shift_i(sh_q),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );
endmodule

// ===== tb/sv/quantized_conv2d_requant_tb.sv =====
// Self-checking testbench for the quantized 2D convolution with requantization.
module quantized_conv2d_requant_tb;

  typedef struct {
    bit       pixel;
    bit [7:0] sample;
    bit       last;
  } word_t;

  typedef struct {
    bit [7:0] value;
    bit [7:0] row;
    bit [7:0] col;
    bit       last;
  } conv_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // sample
  logic        s_axis_tuser = 1'b0; // req_type
  logic        s_axis_tlast = 1'b0; // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // out_value, out_row, out_col
  logic        m_axis_tlast;        // out_last
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  quantized_conv2d_requant DUT (.*);

  // Shadow of the block: configuration and state.
  int unsigned img_w = 1, ker_w = 1, rq_shift = 0;
  int          in_zp = 0, wt_zp = 0, out_zp = 0;
  longint      bias = 0, scale = 1;
  int          kernel_mem [qconv_pkg::KStore];
  int          line_mem [qconv_pkg::LStore];
  int unsigned ker_cnt = 0, ker_rows = 0, pix_row = 0, pix_col = 0;

  word_t       pending_words [$];
  conv_out_t   expected_outs [$];
  word_t       cur_word;
  int          send_idle_pct = 0, recv_stall_pct = 0;
  int          mismatches = 0;
  int          cycles = 0;
  int          random_words = 0;
  bit          take;

  initial forever #5 clk_i = ~clk_i;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void store_reg(qconv_pkg::reg_idx_e idx, logic [31:0] d);
    case (idx)
      qconv_pkg::RegImageWidth:  img_w = d[8:0];
      qconv_pkg::RegKernelWidth: ker_w = d[3:0];
      qconv_pkg::RegInputZp:     in_zp = $signed(d[8:0]);
      qconv_pkg::RegWeightZp:    wt_zp = $signed(d[8:0]);
      qconv_pkg::RegOutputZp:    out_zp = $signed(d[8:0]);
      qconv_pkg::RegAccBias:     bias = $signed(d);
      qconv_pkg::RegScale:       scale = $signed(d[15:0]);
      qconv_pkg::RegShift:       rq_shift = d[5:0];
      default: ;
    endcase
  endfunction

  // Advances the shadow by one word and queues the output it causes.
  function automatic void conv_step(word_t w);
    int unsigned kw, iw, row, col, r0, c0;
    longint      acc;
    int          s;
    conv_out_t   o;
    kw = clamp_dim(ker_w, qconv_pkg::MaxKernel);
    iw = clamp_dim(img_w, qconv_pkg::MaxWidth);
    s = $signed(w.sample);
    if (!w.pixel) begin
      if (ker_cnt < qconv_pkg::KStore) begin
        kernel_mem[ker_cnt] = s + wt_zp;
        ker_cnt++;
      end
      if (w.last) begin
        ker_rows = (ker_cnt / kw > qconv_pkg::MaxKernel) ? qconv_pkg::MaxKernel : ker_cnt / kw;
        ker_cnt = 0;
        pix_row = 0;
        pix_col = 0;
      end else begin
        ker_rows = 0;
      end
      return;
    end
    row = pix_row;
    col = (pix_col >= iw) ? iw - 1 : pix_col;
    line_mem[(row % qconv_pkg::MaxKernel) * qconv_pkg::MaxWidth + col] = s + in_zp;
    if (ker_rows >= 1 && kw <= iw && row + 1 >= ker_rows && col + 1 >= kw) begin
      r0 = row + 1 - ker_rows;
      c0 = col + 1 - kw;
      acc = 0;
      for (int i = 0; i < ker_rows; i++)
        for (int j = 0; j < kw; j++)
          acc += longint'(line_mem[((r0 + i) % qconv_pkg::MaxKernel) * qconv_pkg::MaxWidth
                                   + c0 + j]) *
                 longint'(kernel_mem[(i * kw + j) % qconv_pkg::KStore]);
      acc = ((acc + bias) * scale) >>> rq_shift;
      if (acc < 0) acc = 0;
      acc += out_zp;
      if (acc > 127) acc = 127;
      if (acc < -128) acc = -128;
      o.value = acc[7:0];
      o.row = r0[7:0];
      o.col = c0[7:0];
      o.last = w.last;
      expected_outs.push_back(o);
    end
    if (w.last) begin
      pix_row = 0;
      pix_col = 0;
    end else if (col + 1 >= iw) begin
      pix_col = 0;
      if (pix_row < 16'hFFFF) pix_row++;
    end else begin
      pix_col = col + 1;
    end
  endfunction

  // Input driver.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      take = s_axis_tvalid && s_axis_tready;
      if (take) conv_step(cur_word);
      if ((!s_axis_tvalid || take) && pending_words.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        cur_word = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cur_word.pixel;
        s_axis_tdata <= cur_word.sample;
        s_axis_tlast <= cur_word.last;
      end else if (take) begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output monitor.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_outs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected output word %h last %0d", m_axis_tdata, m_axis_tlast);
        end else begin
          conv_out_t e;
          e = expected_outs.pop_front();
          if (m_axis_tdata[7:0] !== e.value || m_axis_tdata[15:8] !== e.row ||
              m_axis_tdata[23:16] !== e.col || m_axis_tlast !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %0d row %0d col %0d last %0d, got %0d %0d %0d %0d",
                       $signed(e.value), e.row, e.col, e.last,
                       $signed(m_axis_tdata[7:0]), m_axis_tdata[15:8],
                       m_axis_tdata[23:16], m_axis_tlast);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
    if (cycles > 4000000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(qconv_pkg::reg_idx_e idx, logic [31:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    store_reg(idx, d);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every queued word is taken and every output has arrived.
  task automatic drain();
    while (pending_words.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_outs.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic set_all(logic [31:0] w, logic [31:0] kw, logic [31:0] izp,
                         logic [31:0] wzp, logic [31:0] ozp, logic [31:0] b,
                         logic [31:0] sc, logic [31:0] sh, int mode);
    drain();
    write_reg(qconv_pkg::RegImageWidth, w);
    write_reg(qconv_pkg::RegKernelWidth, kw);
    write_reg(qconv_pkg::RegInputZp, izp);
    write_reg(qconv_pkg::RegWeightZp, wzp);
    write_reg(qconv_pkg::RegOutputZp, ozp);
    write_reg(qconv_pkg::RegAccBias, b);
    write_reg(qconv_pkg::RegScale, sc);
    write_reg(qconv_pkg::RegShift, sh);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
      default: begin send_idle_pct = 15; recv_stall_pct = 15; end
    endcase
  endtask

  task automatic push_word(bit pixel, bit [7:0] s, bit last);
    word_t w;
    w.pixel = pixel;
    w.sample = s;
    w.last = last;
    pending_words.push_back(w);
  endtask

  task automatic push_kernel(int n);
    for (int i = 0; i < n; i++) push_word(1'b0, $urandom, i == n - 1);
  endtask

  task automatic push_image(int n);
    for (int i = 0; i < n; i++) push_word(1'b1, $urandom, i == n - 1);
  endtask

  function automatic logic [31:0] rand_zp();
    case ($urandom_range(5))
      0: return -255;
      1: return 255;
      default: return $urandom_range(510) - 255;
    endcase
  endfunction

  initial begin
    int phase, kw, rows, iw, nimg, pix;
    logic [31:0] b, sc, sh;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: pixel with no kernel, 1x1 kernel, sample extremes.
    push_word(1'b1, 8'd5, 1'b0);
    push_word(1'b0, 8'h7F, 1'b1);
    push_word(1'b1, 8'h80, 1'b0);
    push_word(1'b1, 8'h7F, 1'b0);
    push_word(1'b1, 8'h00, 1'b0);
    push_word(1'b1, 8'hFF, 1'b1);
    // Zero widths act as one; large positive saturation.
    set_all(0, 0, 255, 255, 255, 32'h7FFFFFFF, 32767, 0, 1);
    push_word(1'b0, 8'h80, 1'b1);
    push_image(3);
    // Negative extremes and the largest shift.
    set_all(2, 2, -255, -255, -255, 32'h80000000, -32768, 63, 2);
    push_kernel(4);
    push_image(4);
    // Kernel wider than the image; oversize kernel width acts as eight.
    set_all(3, 15, 10, -10, 0, 0, 1, 0, 3);
    push_kernel(16);
    push_image(6);
    // Overlong load: weights past the store are dropped.
    set_all(9, 8, rand_zp(), rand_zp(), 0, 0, 1, 10, 0);
    push_kernel(70);
    push_image(72);

    phase = 4;
    while (random_words < 650) begin
      kw = $urandom_range(1, 4);
      iw = $urandom_range(kw, 12);
      b = ($urandom_range(3) == 0) ? $urandom : $urandom_range(20000) - 10000;
      sc = ($urandom_range(3) == 0) ? $urandom : $urandom_range(200) - 100;
      sh = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(8, 20);
      set_all(iw, kw, rand_zp(), rand_zp(), rand_zp(), b, sc, sh, phase);
      phase++;
      rows = $urandom_range(1, 4);
      // Now and then a load broken off and pixels arriving meanwhile.
      if ($urandom_range(4) == 0) begin
        for (int i = 0; i < $urandom_range(1, 3); i++)
          push_word(1'b0, $urandom, 1'b0);
        pix = $urandom_range(1, 5);
        for (int i = 0; i < pix; i++) push_word(1'b1, $urandom, 1'b0);
        random_words += pix;
      end
      push_kernel(rows * kw + (($urandom_range(5) == 0) ? $urandom_range(1, 3) : 0));
      random_words += rows * kw;
      nimg = $urandom_range(1, 3);
      for (int k = 0; k < nimg; k++) begin
        pix = iw * $urandom_range(rows, 6) - (($urandom_range(3) == 0) ? 1 : 0);
        if (pix < 1) pix = 1;
        push_image(pix);
        random_words += pix;
      end
    end

    // Widest image: a width above the maximum acts as the maximum.
    set_all(300, 8, rand_zp(), rand_zp(), 0, 0, 3, 12, 3);
    push_kernel(8);
    push_image(qconv_pkg::MaxWidth);

    drain();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
